@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Check that an implication's consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/masmp_pkg.sv @@
package masmp_pkg;

   localparam int MaxDim    = 8;
   localparam int FracBits  = 16;
   localparam int DataWidth = 32;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_POW = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_OPERATION = 3'd0,
      REG_ROWS_A    = 3'd1,
      REG_COLS_A    = 3'd2,
      REG_COLS_B    = 3'd3,
      REG_POWER     = 3'd4
   } reg_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_EW_RD,
      ST_EW_WR,
      ST_MM_RD,
      ST_MM_MUL,
      ST_MM_RND,
      ST_MM_ACC,
      ST_MM_WR,
      ST_CPY_RD,
      ST_CPY_WR,
      ST_OUT_RD,
      ST_OUT_HOLD,
      ST_ERR
   } state_type;

endpackage

@@ rtl/matrix_add_sub_mul_power.sv @@
// Add/subtract reads and writes each element after the last B word (EW_RD,
// EW_WR); multiply and power run each multiply-accumulate step (MM_RD, MM_MUL,
// MM_RND, MM_ACC) through one shared multiplier, write each result (MM_WR) and
// copy (CPY_RD, CPY_WR) between powers. A result word is held until taken.
// Loading takes one word per cycle in ST_LOAD. Reset (synchronous, active high)
// sets registers to defaults and clears the run; element stores are not cleared.
`include "assert_macros.svh"

module matrix_add_sub_mul_power #(
   parameter int MAX_DIM    = masmp_pkg::MaxDim,
   parameter int FRAC_BITS  = masmp_pkg::FracBits,
   parameter int DATA_WIDTH = masmp_pkg::DataWidth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_value,
   input  logic                req_second_matrix,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_result_value,
   output logic [2:0]          rsp_row_index,
   output logic [2:0]          rsp_col_index,
   output logic                rsp_status,
   output logic                rsp_last,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [7:0]          csr_data
);

   localparam int Cells = MAX_DIM * MAX_DIM;
   localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;
   localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM + 1) : 1;
   localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int PW    = 2 * DATA_WIDTH + 1;
   localparam int CW    = AW + 1;
   localparam logic signed [DATA_WIDTH-1:0] WMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] WMin = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // configuration
   masmp_pkg::op_type op_ff;
   logic [3:0] rows_ff, cola_ff, colb_ff;
   logic [7:0] pow_ff;

   logic [DW-1:0] ra, ca, cb;
   function automatic logic [DW-1:0] clamp_dim(input logic [3:0] d);
      logic [DW-1:0] r;
      begin
         if (d == 4'd0) r = DW'(1);
         else if (32'(d) > MAX_DIM) r = DW'(MAX_DIM);
         else r = DW'(d);
         return r;
      end
   endfunction
   assign ra = clamp_dim(rows_ff);
   assign ca = clamp_dim(cola_ff);
   assign cb = clamp_dim(colb_ff);

   logic [CW-1:0] size_a, size_b;
   assign size_a = CW'(ra * ca);
   assign size_b = (op_ff == masmp_pkg::OP_MUL) ? CW'(ca * cb) :
                   (op_ff == masmp_pkg::OP_POW) ? CW'(0) : size_a;

   // memories
   logic signed [DATA_WIDTH-1:0] mem_a [Cells];
   logic signed [DATA_WIDTH-1:0] mem_b [Cells];
   logic signed [DATA_WIDTH-1:0] mem_w [Cells];
   logic signed [DATA_WIDTH-1:0] mem_t [Cells];
   logic signed [DATA_WIDTH-1:0] rd_x_ff, rd_y_ff;

   // sequencer state
   masmp_pkg::state_type state_ff, state_in;
   logic [CW-1:0] load_ff, load_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, t_ff, t_in;
   logic [7:0]    pass_ff, pass_in;
   logic signed [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff;
   logic signed [DATA_WIDTH-1:0] prnd_ff;

   // rsp word
   logic                         ovalid_ff, ovalid_in;
   logic [2:0] orow_ff, ocol_ff;
   logic       ostat_ff, olast_ff;

   // dims of the current product: rows r, inner k, cols c
   logic [DW-1:0] m_r, m_k, m_c;
   logic          pow_mode;
   assign pow_mode = (op_ff == masmp_pkg::OP_POW);
   assign m_r = ra;
   assign m_k = pow_mode ? ra : ca;
   assign m_c = pow_mode ? ra : cb;

   // output shape
   logic [DW-1:0] o_c;
   assign o_c = (op_ff == masmp_pkg::OP_MUL) ? cb : (pow_mode ? ra : ca);

   logic [AW-1:0] addr_x, addr_y, addr_z, addr_o;
   assign addr_x = AW'(32'(i_ff) * 32'(m_k) + 32'(t_ff));
   assign addr_y = AW'(32'(t_ff) * 32'(m_c) + 32'(j_ff));
   assign addr_z = AW'(32'(i_ff) * 32'(m_c) + 32'(j_ff));
   assign addr_o = AW'(32'(i_ff) * 32'(o_c) + 32'(j_ff));

   logic accept_in, accept_out, expect_b, item_ok, load_done;
   assign accept_in  = req_valid && !req_stall;
   assign accept_out = rsp_valid && !rsp_stall;
   assign expect_b   = (load_ff >= size_a);
   assign item_ok    = expect_b ? (req_second_matrix && (load_ff - size_a < size_b))
                                : !req_second_matrix;
   assign load_done  = (load_ff + CW'(1) == size_a + size_b);

   // clamp input word to the data width
   logic signed [DATA_WIDTH-1:0] in_word;
   always_comb begin
      if (DATA_WIDTH >= 32) begin
         in_word = DATA_WIDTH'(req_value);
      end else if (64'(signed'(req_value)) > 64'(WMax)) begin
         in_word = WMax;
      end else if (64'(signed'(req_value)) < 64'(WMin)) begin
         in_word = WMin;
      end else begin
         in_word = DATA_WIDTH'(req_value);
      end
   end

   function automatic logic signed [DATA_WIDTH-1:0] sat_add(
      input logic signed [DATA_WIDTH-1:0] a, input logic signed [DATA_WIDTH-1:0] b);
      logic signed [DATA_WIDTH:0] s;
      begin
         s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
         if (s > $signed({1'b0, WMax})) return WMax;
         if (s < $signed({1'b1, WMin})) return WMin;
         return s[DATA_WIDTH-1:0];
      end
   endfunction

   // round half away from zero, then saturate
   logic [PW-1:0] mag, magr;
   logic          pneg;
   logic [PW-1:0] lim;
   logic signed [DATA_WIDTH-1:0] rnd_val;
   always_comb begin
      pneg = prod_ff[PW-1];
      mag  = pneg ? PW'(-prod_ff) : PW'(prod_ff);
      if (FRAC_BITS > 0) begin
         magr = (mag + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      end else begin
         magr = mag;
      end
      lim = pneg ? PW'({1'b0, WMax}) + PW'(1) : PW'({1'b0, WMax});
      if (magr > lim) magr = lim;
      rnd_val = pneg ? DATA_WIDTH'(-magr) : DATA_WIDTH'(magr);
   end

   logic last_ij_o, last_t, last_j_m, last_i_m, last_j_o, last_i_o;
   assign last_t   = (32'(t_ff) + 1 == 32'(m_k));
   assign last_j_m = (32'(j_ff) + 1 == 32'(m_c));
   assign last_i_m = (32'(i_ff) + 1 == 32'(m_r));
   assign last_j_o = (32'(j_ff) + 1 == 32'(o_c));
   assign last_i_o = (32'(i_ff) + 1 == 32'(ra));
   assign last_ij_o = last_j_o && last_i_o;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         masmp_pkg::ST_LOAD: begin
            if (accept_in && item_ok) begin
               if (!expect_b && pow_mode && load_ff + CW'(1) == size_a) begin
                  if (ra != ca) state_in = masmp_pkg::ST_ERR;
                  else if (pow_ff > 8'd1) state_in = masmp_pkg::ST_MM_RD;
                  else state_in = masmp_pkg::ST_OUT_RD;
               end else if (!pow_mode && load_done) begin
                  state_in = (op_ff == masmp_pkg::OP_MUL) ? masmp_pkg::ST_MM_RD
                                                          : masmp_pkg::ST_EW_RD;
               end
            end
         end
         masmp_pkg::ST_EW_RD:  state_in = masmp_pkg::ST_EW_WR;
         masmp_pkg::ST_EW_WR:
            state_in = last_ij_o ? masmp_pkg::ST_OUT_RD : masmp_pkg::ST_EW_RD;
         masmp_pkg::ST_MM_RD:  state_in = masmp_pkg::ST_MM_MUL;
         masmp_pkg::ST_MM_MUL: state_in = masmp_pkg::ST_MM_RND;
         masmp_pkg::ST_MM_RND: state_in = masmp_pkg::ST_MM_ACC;
         masmp_pkg::ST_MM_ACC:
            state_in = last_t ? masmp_pkg::ST_MM_WR : masmp_pkg::ST_MM_RD;
         masmp_pkg::ST_MM_WR: begin
            if (!(last_j_m && last_i_m)) state_in = masmp_pkg::ST_MM_RD;
            else if (pow_mode) state_in = masmp_pkg::ST_CPY_RD;
            else state_in = masmp_pkg::ST_OUT_RD;
         end
         masmp_pkg::ST_CPY_RD: state_in = masmp_pkg::ST_CPY_WR;
         masmp_pkg::ST_CPY_WR: begin
            if (!last_ij_o) state_in = masmp_pkg::ST_CPY_RD;
            else if (pass_ff + 8'd1 < pow_ff) state_in = masmp_pkg::ST_MM_RD;
            else state_in = masmp_pkg::ST_OUT_RD;
         end
         masmp_pkg::ST_OUT_RD: state_in = masmp_pkg::ST_OUT_HOLD;
         masmp_pkg::ST_OUT_HOLD: begin
            if (accept_out) state_in = olast_ff ? masmp_pkg::ST_LOAD
                                                : masmp_pkg::ST_OUT_RD;
         end
         masmp_pkg::ST_ERR: if (accept_out) state_in = masmp_pkg::ST_LOAD;
         default: state_in = masmp_pkg::ST_LOAD;
      endcase
   end

   // counters and datapath control
   always_comb begin
      load_in   = load_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      t_in      = t_ff;
      pass_in   = pass_ff;
      acc_in    = acc_ff;
      ovalid_in = ovalid_ff;
      unique case (state_ff)
         masmp_pkg::ST_LOAD: begin
            i_in = '0; j_in = '0; t_in = '0; acc_in = '0; pass_in = 8'd1;
            if (accept_in && item_ok) begin
               load_in = (state_in != masmp_pkg::ST_LOAD) ? '0 : load_ff + CW'(1);
               ovalid_in = (state_in == masmp_pkg::ST_ERR);
            end
         end
         masmp_pkg::ST_EW_WR, masmp_pkg::ST_CPY_WR: begin
            if (last_j_o) begin
               j_in = '0;
               i_in = last_i_o ? '0 : i_ff + IW'(1);
            end else begin
               j_in = j_ff + IW'(1);
            end
            if (state_ff == masmp_pkg::ST_CPY_WR && last_ij_o) pass_in = pass_ff + 8'd1;
         end
         masmp_pkg::ST_MM_ACC: begin
            acc_in = sat_add(acc_ff, prnd_ff);
            if (!last_t) t_in = t_ff + IW'(1);
         end
         masmp_pkg::ST_MM_WR: begin
            acc_in = '0;
            t_in   = '0;
            if (last_j_m) begin
               j_in = '0;
               i_in = last_i_m ? '0 : i_ff + IW'(1);
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         masmp_pkg::ST_OUT_RD: ovalid_in = 1'b1;
         masmp_pkg::ST_OUT_HOLD: begin
            if (accept_out) begin
               ovalid_in = 1'b0;
               if (last_j_o) begin
                  j_in = '0;
                  i_in = last_i_o ? '0 : i_ff + IW'(1);
               end else begin
                  j_in = j_ff + IW'(1);
               end
            end
         end
         masmp_pkg::ST_ERR: if (accept_out) ovalid_in = 1'b0;
         default: ;
      endcase
      // any register write restarts the load
      if (csr_write && csr_index <= masmp_pkg::REG_POWER) load_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= masmp_pkg::ST_LOAD;
         load_ff   <= '0;
         ovalid_ff <= 1'b0;
         i_ff <= '0; j_ff <= '0; t_ff <= '0;
         pass_ff <= 8'd1;
         acc_ff  <= '0;
         op_ff   <= masmp_pkg::OP_ADD;
         rows_ff <= 4'd1; cola_ff <= 4'd1; colb_ff <= 4'd1;
         pow_ff  <= 8'd1;
      end else begin
         state_ff  <= state_in;
         load_ff   <= load_in;
         ovalid_ff <= ovalid_in;
         i_ff <= i_in; j_ff <= j_in; t_ff <= t_in;
         pass_ff <= pass_in;
         acc_ff  <= acc_in;
         if (csr_write) begin
            priority case (csr_index)
               masmp_pkg::REG_OPERATION: op_ff   <= masmp_pkg::op_type'(csr_data[1:0]);
               masmp_pkg::REG_ROWS_A:    rows_ff <= csr_data[3:0];
               masmp_pkg::REG_COLS_A:    cola_ff <= csr_data[3:0];
               masmp_pkg::REG_COLS_B:    colb_ff <= csr_data[3:0];
               masmp_pkg::REG_POWER:     pow_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // memories and datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= PW'(rd_x_ff) * PW'(rd_y_ff);
      prnd_ff <= rnd_val;
      unique case (state_ff)
         masmp_pkg::ST_LOAD: begin
            if (accept_in && item_ok) begin
               if (!expect_b) mem_a[AW'(load_ff)] <= in_word;
               else mem_b[AW'(load_ff - size_a)] <= in_word;
            end
            // error word carries a zero value
            if (state_in == masmp_pkg::ST_ERR) rd_x_ff <= '0;
         end
         masmp_pkg::ST_EW_RD: begin
            rd_x_ff <= mem_a[addr_o];
            rd_y_ff <= mem_b[addr_o];
         end
         masmp_pkg::ST_EW_WR: begin
            if (op_ff == masmp_pkg::OP_ADD) mem_w[addr_o] <= sat_add(rd_x_ff, rd_y_ff);
            else mem_w[addr_o] <= sat_add(rd_x_ff,
                                  (rd_y_ff == WMin) ? WMax : -rd_y_ff);
         end
         masmp_pkg::ST_MM_RD: begin
            // power: x is the running product (or A on the first pass)
            if (pow_mode && pass_ff > 8'd1) rd_x_ff <= mem_w[addr_x];
            else rd_x_ff <= mem_a[addr_x];
            rd_y_ff <= pow_mode ? mem_a[addr_y] : mem_b[addr_y];
         end
         masmp_pkg::ST_MM_WR: begin
            if (pow_mode) mem_t[addr_z] <= acc_ff;
            else mem_w[addr_z] <= acc_ff;
         end
         masmp_pkg::ST_CPY_RD: rd_x_ff <= mem_t[addr_o];
         masmp_pkg::ST_CPY_WR: mem_w[addr_o] <= rd_x_ff;
         masmp_pkg::ST_OUT_RD: begin
            if (pow_mode && pow_ff <= 8'd1) rd_x_ff <= mem_a[addr_o];
            else rd_x_ff <= mem_w[addr_o];
         end
         default: ;
      endcase
   end

   // result word, held in rd_x_ff while the word waits
   logic signed [DATA_WIDTH-1:0] oval_in;
   always_comb begin
      if (DATA_WIDTH <= 32) oval_in = rd_x_ff;
      else if (rd_x_ff > DATA_WIDTH'(64'sd2147483647)) oval_in = DATA_WIDTH'(64'sd2147483647);
      else if (rd_x_ff < DATA_WIDTH'(-64'sd2147483648)) oval_in = DATA_WIDTH'(-64'sd2147483648);
      else oval_in = rd_x_ff;
   end

   always_ff @(posedge clock) begin
      if (state_ff == masmp_pkg::ST_OUT_RD) begin
         orow_ff  <= 3'(i_ff);
         ocol_ff  <= 3'(j_ff);
         ostat_ff <= 1'b0;
         olast_ff <= last_ij_o;
      end else if (state_ff == masmp_pkg::ST_LOAD && state_in == masmp_pkg::ST_ERR) begin
         orow_ff  <= 3'd0;
         ocol_ff  <= 3'd0;
         ostat_ff <= 1'b1;
         olast_ff <= 1'b1;
      end
   end

   assign req_stall        = (state_ff != masmp_pkg::ST_LOAD);
   assign rsp_valid        = ovalid_ff;
   assign rsp_result_value = 32'(oval_in);
   assign rsp_row_index    = orow_ff;
   assign rsp_col_index    = ocol_ff;
   assign rsp_status       = ostat_ff;
   assign rsp_last         = olast_ff;

   `ASSERT_IMPL(a_valid_state, clock, reset, rsp_valid,
      state_ff == masmp_pkg::ST_OUT_HOLD || state_ff == masmp_pkg::ST_ERR,
      "result word valid outside an output state")
   `ASSERT_IMPL(a_err_last, clock, reset, rsp_valid && rsp_status, rsp_last,
      "error word is not last")
   `ASSERT_NEXT(a_last_done, clock, reset, accept_out && rsp_last,
      !rsp_valid && state_ff == masmp_pkg::ST_LOAD,
      "block did not return to loading after the last word")
   `ASSERT_IMPL(a_no_load, clock, reset, rsp_valid, req_stall,
      "input taken while a result is pending")

endmodule
